// ===== hdl/jtl_pkg.sv =====
// Package for the JSON token lexer: token kinds, lexer modes, byte classes
// and the keyword spelling tables. No dependencies.
package jtl_pkg;

  localparam int unsigned OUT_POS_W  = 32;
  localparam int unsigned OUT_LINE_W = 24;

  typedef enum logic [3:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_COMMA    = 4'd4,
    KIND_COLON    = 4'd5,
    KIND_STRING   = 4'd6,
    KIND_NUMBER   = 4'd7,
    KIND_TRUE     = 4'd8,
    KIND_FALSE    = 4'd9,
    KIND_NULL     = 4'd10,
    KIND_ERROR    = 4'd11,
    KIND_END      = 4'd12
  } tok_kind_e;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_STRING  = 6'b000010,
    MODE_ESCAPE  = 6'b000100,
    MODE_NUMBER  = 6'b001000,
    MODE_KEYWORD = 6'b010000,
    MODE_ERROR   = 6'b100000
  } mode_e;

  typedef enum logic [3:0] {
    CLS_PUNCT,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_NUMX,
    CLS_KW_T,
    CLS_KW_F,
    CLS_KW_N,
    CLS_BLANK,
    CLS_LF,
    CLS_CR,
    CLS_OTHER
  } byte_cls_e;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  typedef struct packed {
    byte_cls_e   cls;
    logic [7:0]  data;
    logic        eot;
  } item_t;

  function automatic byte_cls_e jtl_classify(input logic [7:0] b);
    byte_cls_e cls;
    case (b) inside
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h3A: cls = CLS_PUNCT;
      8'h22:                                    cls = CLS_QUOTE;
      8'h5C:                                    cls = CLS_BSLASH;
      [8'h30:8'h39]:                            cls = CLS_DIGIT;
      8'h2D:                                    cls = CLS_MINUS;
      8'h2B, 8'h2E, 8'h65, 8'h45:               cls = CLS_NUMX;
      8'h74:                                    cls = CLS_KW_T;
      8'h66:                                    cls = CLS_KW_F;
      8'h6E:                                    cls = CLS_KW_N;
      8'h20, 8'h09:                             cls = CLS_BLANK;
      8'h0A:                                    cls = CLS_LF;
      8'h0D:                                    cls = CLS_CR;
      default:                                  cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

  function automatic tok_kind_e jtl_punct_kind(input logic [7:0] b);
    tok_kind_e k;
    case (b)
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h2C:   k = KIND_COMMA;
      default: k = KIND_COLON;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] jtl_kw_len(input logic [1:0] id);
    logic [2:0] len;
    case (id)
      KW_FALSE: len = 3'd5;
      default:  len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic tok_kind_e jtl_kw_kind(input logic [1:0] id);
    tok_kind_e k;
    case (id)
      KW_FALSE: k = KIND_FALSE;
      KW_NULL:  k = KIND_NULL;
      default:  k = KIND_TRUE;
    endcase
    return k;
  endfunction

  // ASCII spelling of true / false / null, indexed by character position
  function automatic logic [7:0] jtl_kw_char(input logic [1:0] id, input logic [2:0] ix);
    logic [7:0] ch;
    case ({id, ix})
      {KW_TRUE, 3'd0}:  ch = 8'h74;
      {KW_TRUE, 3'd1}:  ch = 8'h72;
      {KW_TRUE, 3'd2}:  ch = 8'h75;
      {KW_TRUE, 3'd3}:  ch = 8'h65;
      {KW_FALSE, 3'd0}: ch = 8'h66;
      {KW_FALSE, 3'd1}: ch = 8'h61;
      {KW_FALSE, 3'd2}: ch = 8'h6C;
      {KW_FALSE, 3'd3}: ch = 8'h73;
      {KW_FALSE, 3'd4}: ch = 8'h65;
      {KW_NULL, 3'd0}:  ch = 8'h6E;
      {KW_NULL, 3'd1}:  ch = 8'h75;
      {KW_NULL, 3'd2}:  ch = 8'h6C;
      {KW_NULL, 3'd3}:  ch = 8'h6C;
      default:          ch = 8'h74;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/json_token_lexer_unit.sv =====
// JSON token lexer, one byte per clock while the output is not stalled and no
// byte yields two tokens. Each accepted byte (or end-of-text transfer, tlast
// high) is classified and numbered by the front end, waits in a two-entry
// queue, and is lexed by the back end, which drives the registered output. A
// byte yielding two tokens (a number closed by punctuation or an error byte,
// or end of text after an open token) holds its queue entry while the single
// output register sends them in turn. From input to output a byte passes the
// queue entry and the output register. No reset sweep.
// Depends on jtl_pkg, jtl_front, jtl_queue and jtl_back.
module json_token_lexer_unit import jtl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LINE_BITS     = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_in
  input  logic         s_axis_tlast,   // end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // [31:0] start_pos, [63:32] end_pos,
                                       // [87:64] line_no, [111:88] start_column
  output logic [3:0]   m_axis_tuser,   // [3:0] token_kind
  output logic         m_axis_tlast    // last_in_run
);

  localparam int unsigned QW = $bits(item_t) + POSITION_BITS;

  logic                     q_ready, push, pop, q_valid;
  item_t                    push_item, head_item;
  logic [POSITION_BITS-1:0] push_pos, head_pos;
  logic [QW-1:0]            head_data;

  tok_kind_e                out_kind;
  logic [POSITION_BITS-1:0] out_start, out_end;
  logic [LINE_BITS-1:0]     out_line, out_col;
  logic [63:0]              start_ext, end_ext;
  logic [31:0]              line_ext, col_ext;

  jtl_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_eot_i    (s_axis_tlast),
    .q_ready_i   (q_ready),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_item_o (push_item),
    .push_pos_o  (push_pos)
  );

  jtl_queue #(.WIDTH(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_pos, push_item}),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_data)
  );

  assign head_item = head_data[$bits(item_t)-1:0];
  assign head_pos  = head_data[QW-1:$bits(item_t)];

  jtl_back #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pos_i     (head_pos),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_start_o (out_start),
    .out_end_o   (out_end),
    .out_line_o  (out_line),
    .out_col_o   (out_col),
    .out_last_o  (m_axis_tlast)
  );

  assign start_ext = 64'(out_start);
  assign end_ext   = 64'(out_end);
  assign line_ext  = 32'(out_line);
  assign col_ext   = 32'(out_col);

  assign m_axis_tdata = {col_ext[OUT_LINE_W-1:0], line_ext[OUT_LINE_W-1:0],
                         end_ext[OUT_POS_W-1:0], start_ext[OUT_POS_W-1:0]};
  assign m_axis_tuser = out_kind;

endmodule

// ===== hdl/jtl_front.sv =====
// Front end of the JSON token lexer: accepts bytes, classifies them and
// tracks the byte position. Depends on jtl_pkg.
module jtl_front import jtl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     in_eot_i,
  input  logic                     q_ready_i,
  output logic                     in_ready_o,
  output logic                     push_o,
  output item_t                    push_item_o,
  output logic [POSITION_BITS-1:0] push_pos_o
);

  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_inc;
  logic                     accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign push_o     = accept;

  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;

  // end of text carries the last position, then the count restarts
  assign push_pos_o       = in_eot_i ? pos_q : pos_inc;
  assign push_item_o.cls  = jtl_classify(in_byte_i);
  assign push_item_o.data = in_byte_i;
  assign push_item_o.eot  = in_eot_i;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = in_eot_i ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== hdl/jtl_queue.sv =====
// Two-entry queue between the lexer front and back ends.
// Depends on nothing but its width parameter.
module jtl_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && valid_o)) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i && valid_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i && ready_o) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !pop_i) |=> count_q == 2'd2)
    else $error("full queue lost an entry");

  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers inconsistent");

endmodule

// ===== hdl/jtl_back.sv =====
// Back end of the JSON token lexer: lexer state machine, line and column
// tracking, token building and the output register. Depends on jtl_pkg.
module jtl_back import jtl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LINE_BITS     = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  item_t                    q_item_i,
  input  logic [POSITION_BITS-1:0] q_pos_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output tok_kind_e                out_kind_o,
  output logic [POSITION_BITS-1:0] out_start_o,
  output logic [POSITION_BITS-1:0] out_end_o,
  output logic [LINE_BITS-1:0]     out_line_o,
  output logic [LINE_BITS-1:0]     out_col_o,
  output logic                     out_last_o
);

  typedef struct packed {
    tok_kind_e                kind;
    logic [POSITION_BITS-1:0] spos;
    logic [POSITION_BITS-1:0] epos;
    logic [LINE_BITS-1:0]     col;
  } tok_t;

  mode_e                    mode_q, mode_d;
  logic [1:0]               kwid_q, kwid_d;
  logic [2:0]               kwix_q, kwix_d;
  logic [LINE_BITS-1:0]     line_q, line_d, col_q, col_d, col_inc;
  logic [POSITION_BITS-1:0] tstart_q, tstart_d, pos_inc;
  logic [LINE_BITS-1:0]     tcol_q, tcol_d;
  logic                     phase_q;

  tok_t                     tok [2];
  logic [1:0]               cnt;
  logic                     do_idle;
  logic [1:0]               kw_eff;
  logic [2:0]               kw_len;

  logic                     out_valid_q;
  tok_t                     out_tok_q;
  logic [LINE_BITS-1:0]     out_line_q;
  logic                     out_last_q;
  logic                     go;

  assign col_inc = (col_q == '1) ? col_q : col_q + 1'b1;
  assign pos_inc = (q_pos_i == '1) ? q_pos_i : q_pos_i + 1'b1;
  assign kw_eff  = (kwid_q == 2'd3) ? KW_TRUE : kwid_q;
  assign kw_len  = jtl_kw_len(kw_eff);

  always_comb begin
    mode_d   = mode_q;
    kwid_d   = kwid_q;
    kwix_d   = kwix_q;
    line_d   = line_q;
    col_d    = col_q;
    tstart_d = tstart_q;
    tcol_d   = tcol_q;
    tok[0]   = '0;
    tok[1]   = '0;
    cnt      = 2'd0;
    do_idle  = 1'b0;

    if (q_item_i.eot) begin
      if (mode_q == MODE_NUMBER) begin
        tok[0] = '{KIND_NUMBER, tstart_q, q_pos_i, tcol_q};
        cnt    = 2'd1;
      end else if (mode_q == MODE_STRING || mode_q == MODE_ESCAPE ||
                   mode_q == MODE_KEYWORD) begin
        tok[0] = '{KIND_ERROR, tstart_q, q_pos_i, tcol_q};
        cnt    = 2'd1;
      end
      tok[cnt[0]] = '{KIND_END, q_pos_i, q_pos_i, col_q};
      cnt         = cnt + 2'd1;
      mode_d   = MODE_IDLE;
      kwid_d   = '0;
      kwix_d   = '0;
      line_d   = LINE_BITS'(1);
      col_d    = '0;
      tstart_d = '0;
      tcol_d   = '0;
    end else begin
      col_d = col_inc;
      case (mode_q)
        MODE_IDLE: begin
          do_idle = 1'b1;
        end
        MODE_STRING: begin
          case (q_item_i.cls)
            CLS_QUOTE: begin
              tok[0] = '{KIND_STRING, tstart_q, q_pos_i - 1'b1, tcol_q};
              cnt    = 2'd1;
              mode_d = MODE_IDLE;
            end
            CLS_BSLASH: mode_d = MODE_ESCAPE;
            CLS_CR, CLS_LF: begin
              tok[0] = '{KIND_ERROR, tstart_q, q_pos_i, tcol_q};
              cnt    = 2'd1;
              mode_d = MODE_ERROR;
            end
            default: ;
          endcase
        end
        MODE_ESCAPE: mode_d = MODE_STRING;
        MODE_NUMBER: begin
          if (!(q_item_i.cls inside {CLS_DIGIT, CLS_MINUS, CLS_NUMX})) begin
            tok[0]  = '{KIND_NUMBER, tstart_q, q_pos_i - 1'b1, tcol_q};
            cnt     = 2'd1;
            mode_d  = MODE_IDLE;
            do_idle = 1'b1;
          end
        end
        MODE_KEYWORD: begin
          if (kwix_q < kw_len && q_item_i.data == jtl_kw_char(kw_eff, kwix_q)) begin
            kwix_d = kwix_q + 3'd1;
            if (kwix_q + 3'd1 == kw_len) begin
              tok[0] = '{jtl_kw_kind(kw_eff), tstart_q, q_pos_i, tcol_q};
              cnt    = 2'd1;
              mode_d = MODE_IDLE;
              kwix_d = '0;
            end
          end else begin
            tok[0] = '{KIND_ERROR, tstart_q, q_pos_i, tcol_q};
            cnt    = 2'd1;
            mode_d = MODE_ERROR;
          end
        end
        MODE_ERROR: ;
        default: mode_d = MODE_ERROR;
      endcase

      if (do_idle) begin
        case (q_item_i.cls)
          CLS_PUNCT: begin
            tok[cnt[0]] = '{jtl_punct_kind(q_item_i.data), q_pos_i, q_pos_i, col_inc};
            cnt         = cnt + 2'd1;
          end
          CLS_QUOTE: begin
            mode_d   = MODE_STRING;
            tstart_d = pos_inc;
            tcol_d   = col_inc;
          end
          CLS_DIGIT, CLS_MINUS: begin
            mode_d   = MODE_NUMBER;
            tstart_d = q_pos_i;
            tcol_d   = col_inc;
          end
          CLS_KW_T, CLS_KW_F, CLS_KW_N: begin
            mode_d   = MODE_KEYWORD;
            kwid_d   = (q_item_i.cls == CLS_KW_T) ? KW_TRUE :
                       (q_item_i.cls == CLS_KW_F) ? KW_FALSE : KW_NULL;
            kwix_d   = 3'd1;
            tstart_d = q_pos_i;
            tcol_d   = col_inc;
          end
          CLS_BLANK: ;
          CLS_LF: begin
            line_d = (line_q == '1) ? line_q : line_q + 1'b1;
            col_d  = '0;
          end
          default: begin
            tok[cnt[0]] = '{KIND_ERROR, q_pos_i, q_pos_i, col_inc};
            cnt         = cnt + 2'd1;
            mode_d      = MODE_ERROR;
          end
        endcase
      end
    end
  end

  // a two-token item holds the head entry until its second token is registered
  assign go    = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = go && !(cnt == 2'd2 && !phase_q);

  // line is taken at emission; later bytes may move it on
  always_ff @(posedge clk_i) begin
    if (go && cnt != 2'd0) begin
      out_tok_q  <= phase_q ? tok[1] : tok[0];
      out_line_q <= line_q;
      out_last_q <= !(cnt == 2'd2 && !phase_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      kwid_q      <= '0;
      kwix_q      <= '0;
      line_q      <= LINE_BITS'(1);
      col_q       <= '0;
      tstart_q    <= '0;
      tcol_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (go) begin
        if (cnt != 2'd0) begin
          out_valid_q <= 1'b1;
        end
        if (cnt == 2'd2 && !phase_q) begin
          phase_q <= 1'b1;
        end else begin
          phase_q  <= 1'b0;
          mode_q   <= mode_d;
          kwid_q   <= kwid_d;
          kwix_q   <= kwix_d;
          line_q   <= line_d;
          col_q    <= col_d;
          tstart_q <= tstart_d;
          tcol_q   <= tcol_d;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_tok_q.kind;
  assign out_start_o = out_tok_q.spos;
  assign out_end_o   = out_tok_q.epos;
  assign out_line_o  = out_line_q;
  assign out_col_o   = out_tok_q.col;
  assign out_last_o  = out_last_q;

  a_phase_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> q_valid_i && out_valid_q && !out_last_q)
    else $error("second token pending without its item");

  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && mode_q == MODE_ERROR && !q_item_i.eot) |-> cnt == 2'd0)
    else $error("token emitted in error mode");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count reached zero");

  a_eot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_item_i.eot) |=> out_valid_q && out_last_q && out_tok_q.kind == KIND_END)
    else $error("end of text did not close with an end token");

endmodule

// ===== verif/jtl_token_checker.sv =====
`timescale 1ns / 100ps
// Token checker for json_token_lexer_unit: watches both stream channels, predicts
// the tokens of every accepted byte or end-of-text transfer and compares them
// in order with the output transfers. Depends on jtl_pkg.
module jtl_token_checker import jtl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_in
  input  logic         s_axis_tlast,   // end_of_text
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,   // [31:0] start_pos, [63:32] end_pos,
                                       // [87:64] line_no, [111:88] start_column
  input  logic [3:0]   m_axis_tuser,   // [3:0] token_kind
  input  logic         m_axis_tlast,   // last_in_run
  output int unsigned  mismatch_count_o,
  output int unsigned  tokens_pending_o,
  output int unsigned  tokens_checked_o
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    tok_kind_e               kind;
    logic [OUT_POS_W-1:0]    first_pos;
    logic [OUT_POS_W-1:0]    last_pos;
    logic [OUT_LINE_W-1:0]   line;
    logic [OUT_LINE_W-1:0]   column;
    logic                    run_end;
  } token_t;

  token_t                 token_q[$];
  mode_e                  lex_state;
  logic [1:0]             kw_sel;
  logic [2:0]             kw_pos;
  logic [OUT_POS_W-1:0]   byte_pos;
  logic [OUT_POS_W-1:0]   tok_first;
  logic [OUT_LINE_W-1:0]  line_cnt;
  logic [OUT_LINE_W-1:0]  col_cnt;
  logic [OUT_LINE_W-1:0]  tok_col;
  int unsigned            emitted;
  int unsigned            n_mismatch;
  int unsigned            n_checked;

  function automatic logic [OUT_POS_W-1:0] next_pos(input logic [OUT_POS_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_LINE_W-1:0] next_count(input logic [OUT_LINE_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit is_number_byte(input logic [7:0] b);
    return (b >= "0" && b <= "9") || b == "-" || b == "+" || b == "." || b == "e" ||
           b == "E";
  endfunction

  function automatic string keyword_word(input logic [1:0] id);
    case (id)
      KW_FALSE: return "false";
      KW_NULL:  return "null";
      default:  return "true";
    endcase
  endfunction

  task automatic clear_state();
    lex_state = MODE_IDLE;
    kw_sel    = KW_TRUE;
    kw_pos    = '0;
    byte_pos  = '0;
    line_cnt  = OUT_LINE_W'(1);
    col_cnt   = '0;
    tok_first = '0;
    tok_col   = '0;
  endtask

  task automatic add_token(input tok_kind_e kind, input logic [OUT_POS_W-1:0] first,
                           input logic [OUT_POS_W-1:0] last,
                           input logic [OUT_LINE_W-1:0] column);
    token_t tok;
    tok.kind      = kind;
    tok.first_pos = first;
    tok.last_pos  = last;
    tok.line      = line_cnt;
    tok.column    = column;
    tok.run_end   = 1'b0;
    token_q.push_back(tok);
    emitted++;
  endtask

  // byte seen with no token open
  task automatic open_token(input logic [7:0] b, input logic [OUT_POS_W-1:0] p,
                            input logic [OUT_LINE_W-1:0] c);
    case (b)
      "{": add_token(KIND_LBRACE, p, p, c);
      "}": add_token(KIND_RBRACE, p, p, c);
      "[": add_token(KIND_LBRACKET, p, p, c);
      "]": add_token(KIND_RBRACKET, p, p, c);
      ",": add_token(KIND_COMMA, p, p, c);
      ":": add_token(KIND_COLON, p, p, c);
      default: begin
        if (b == CH_QUOTE) begin
          lex_state = MODE_STRING;
          tok_first = next_pos(p);
          tok_col   = c;
        end else if (b == "-" || (b >= "0" && b <= "9")) begin
          lex_state = MODE_NUMBER;
          tok_first = p;
          tok_col   = c;
        end else if (b == "t" || b == "f" || b == "n") begin
          lex_state = MODE_KEYWORD;
          kw_sel    = (b == "t") ? KW_TRUE : (b == "f") ? KW_FALSE : KW_NULL;
          kw_pos    = 3'd1;
          tok_first = p;
          tok_col   = c;
        end else if (b == CH_LF) begin
          line_cnt = next_count(line_cnt);
          col_cnt  = '0;
        end else if (b != CH_SPACE && b != CH_TAB) begin
          add_token(KIND_ERROR, p, p, c);
          lex_state = MODE_ERROR;
        end
      end
    endcase
  endtask

  task automatic lex_transfer(input logic [7:0] b, input logic eot);
    logic [OUT_POS_W-1:0]  p;
    logic [OUT_LINE_W-1:0] c;
    string                 word;
    token_t                tail;
    emitted = 0;
    if (eot) begin
      if (lex_state == MODE_NUMBER) begin
        add_token(KIND_NUMBER, tok_first, byte_pos, tok_col);
      end else if (lex_state == MODE_STRING || lex_state == MODE_ESCAPE ||
                   lex_state == MODE_KEYWORD) begin
        add_token(KIND_ERROR, tok_first, byte_pos, tok_col);
      end
      add_token(KIND_END, byte_pos, byte_pos, col_cnt);
      clear_state();
    end else begin
      p        = next_pos(byte_pos);
      c        = next_count(col_cnt);
      byte_pos = p;
      col_cnt  = c;
      case (lex_state)
        MODE_IDLE: open_token(b, p, c);
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            add_token(KIND_STRING, tok_first, p - 1'b1, tok_col);
            lex_state = MODE_IDLE;
          end else if (b == CH_BSLASH) begin
            lex_state = MODE_ESCAPE;
          end else if (b == CH_CR || b == CH_LF) begin
            add_token(KIND_ERROR, tok_first, p, tok_col);
            lex_state = MODE_ERROR;
          end
        end
        MODE_ESCAPE: lex_state = MODE_STRING;
        MODE_NUMBER: begin
          if (!is_number_byte(b)) begin
            add_token(KIND_NUMBER, tok_first, p - 1'b1, tok_col);
            lex_state = MODE_IDLE;
            open_token(b, p, c);
          end
        end
        MODE_KEYWORD: begin
          word = keyword_word(kw_sel);
          if (kw_pos < word.len() && b == word[kw_pos]) begin
            kw_pos = kw_pos + 3'd1;
            if (kw_pos == word.len()) begin
              add_token(tok_kind_e'(KIND_TRUE + kw_sel), tok_first, p, tok_col);
              lex_state = MODE_IDLE;
              kw_pos    = '0;
            end
          end else begin
            add_token(KIND_ERROR, tok_first, p, tok_col);
            lex_state = MODE_ERROR;
          end
        end
        default: lex_state = MODE_ERROR;
      endcase
    end
    if (emitted != 0) begin
      tail = token_q.pop_back();
      tail.run_end = 1'b1;
      token_q.push_back(tail);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatch++;
    end
  endfunction

  task automatic check_token();
    token_t want;
    if (token_q.size() == 0) begin
      $error("unexpected token: token_kind %0d, start_pos %0d", m_axis_tuser,
             m_axis_tdata[31:0]);
      n_mismatch++;
    end else begin
      want = token_q.pop_front();
      n_checked++;
      check_field("token_kind", want.kind, m_axis_tuser);
      check_field("start_pos", want.first_pos, m_axis_tdata[31:0]);
      check_field("end_pos", want.last_pos, m_axis_tdata[63:32]);
      check_field("line_no", want.line, m_axis_tdata[87:64]);
      check_field("start_column", want.column, m_axis_tdata[111:88]);
      check_field("last_in_run", want.run_end, m_axis_tlast);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      token_q.delete();
      n_mismatch = 0;
      n_checked  = 0;
      mismatch_count_o <= 0;
      tokens_pending_o <= 0;
      tokens_checked_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        lex_transfer(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_token();
      end
      mismatch_count_o <= n_mismatch;
      tokens_pending_o <= token_q.size();
      tokens_checked_o <= n_checked;
    end
  end

endmodule

// ===== verif/json_token_lexer_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for json_token_lexer_unit: builds JSON-like texts, drives them
// with random gaps and output stalls, and reports the verdict.
// Depends on jtl_pkg, json_token_lexer_unit and jtl_token_checker.
module json_token_lexer_unit_tb;

  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned SETTLE       = 10;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } lex_item_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int unsigned  mismatch_count;
  int unsigned  tokens_pending;
  int unsigned  tokens_checked;

  lex_item_t    text_q[$];
  int unsigned  junk_items  = 0;
  int unsigned  n_texts     = 0;
  int unsigned  items_sent  = 0;
  int unsigned  cycle_count = 0;
  bit           steady_run  = 1'b0;

  json_token_lexer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  jtl_token_checker token_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .tokens_pending_o (tokens_pending),
    .tokens_checked_o (tokens_checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("json_token_lexer_unit test failed");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    lex_item_t it;
    it.data = b;
    it.eot  = 1'b0;
    text_q.push_back(it);
  endtask

  task automatic put_eot();
    lex_item_t it;
    it.data = 8'($urandom_range(0, 255));
    it.eot  = 1'b1;
    text_q.push_back(it);
    n_texts++;
  endtask

  task automatic put_bytes(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic string pick_keyword();
    case ($urandom_range(0, 2))
      0:       return "true";
      1:       return "false";
      default: return "null";
    endcase
  endfunction

  // string token; escapes carry any byte, raw content avoids quote, backslash, CR, LF
  task automatic gen_string(input bit closed);
    int unsigned len;
    logic [7:0]  b;
    put_byte(CH_QUOTE);
    len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_QUOTE || b == CH_BSLASH || b == CH_CR || b == CH_LF ||
          $urandom_range(0, 15) == 0) begin
        put_byte(CH_BSLASH);
        b = 8'($urandom_range(0, 255));
      end
      put_byte(b);
    end
    if (closed) put_byte(CH_QUOTE);
  endtask

  task automatic gen_text();
    string       punct;
    string       digits;
    string       blanks;
    string       word;
    int unsigned n_tok;
    int unsigned pick;
    int unsigned n_prefix;
    bit          after_number;
    punct        = "{}[],:";
    digits       = "0123456789-+.eE";
    blanks       = " \t\n";
    after_number = 1'b0;
    n_tok = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 10);
    for (int k = 0; k < n_tok; k++) begin
      if ($urandom_range(0, 3) == 0) put_byte(blanks[$urandom_range(0, 2)]);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        put_byte(punct[$urandom_range(0, 5)]);
      end else if (pick < 50) begin
        gen_string(1'b1);
      end else if (pick < 70) begin
        if (after_number) put_byte(" ");
        put_byte(($urandom_range(0, 3) == 0) ? "-" : digits[$urandom_range(0, 9)]);
        repeat ($urandom_range(0, 6)) put_byte(digits[$urandom_range(0, 14)]);
      end else if (pick < 88) begin
        put_bytes(pick_keyword());
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 3)) put_byte(blanks[$urandom_range(0, 2)]);
      end else begin
        case ($urandom_range(0, 2))
          0: put_byte(8'($urandom_range(0, 255)));
          1: begin
            word = pick_keyword();
            put_byte(word[0]);
            put_byte(8'($urandom_range(0, 255)));
          end
          default: begin
            gen_string(1'b0);
            put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
          end
        endcase
        repeat ($urandom_range(0, 2)) begin
          put_byte(8'($urandom_range(0, 255)));
          junk_items++;
        end
        put_eot();
        return;
      end
      after_number = (pick >= 50 && pick < 70);
    end
    case ($urandom_range(0, 9))
      0: gen_string(1'b0);
      1: begin
        word     = pick_keyword();
        n_prefix = $urandom_range(1, word.len() - 1);
        for (int i = 0; i < n_prefix; i++) put_byte(word[i]);
      end
      default: ;
    endcase
    put_eot();
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic drive_item(input lex_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.data;
    s_axis_tlast  <= it.eot;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  initial begin : sink_proc
    int unsigned r;
    bit          held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      m_axis_tready <= 1'b1;
      repeat ((r < 20) ? $urandom_range(50, 200) : $urandom_range(1, 12)) @(posedge clk_i);
      m_axis_tready <= 1'b0;
      if (!held_off && items_sent > 700) begin
        held_off = 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        repeat ((r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 50)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned directed_items;
    // end mark on an empty text, escaped LF, empty string, number closed by a
    // brace, tab and LF, null, then open keyword, number and string at end of
    // text, CR inside a string, bytes ignored after an error, error byte 0x00
    put_eot();
    put_bytes("[\"\\\n\"\"\"-1e}\t\nnull f");
    put_eot();
    put_byte("9");
    put_eot();
    put_byte(CH_QUOTE);
    put_byte(CH_CR);
    put_byte(8'hFF);
    put_eot();
    put_byte(8'h00);
    put_eot();
    put_byte(CH_QUOTE);
    put_eot();
    directed_items = text_q.size();
    while (text_q.size() - junk_items < directed_items + RANDOM_ITEMS) gen_text();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (text_q[i]) begin
      if (i % 150 == 0) steady_run = ($urandom_range(0, 3) == 0);
      drive_item(text_q[i]);
    end
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tokens_pending != 0);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d byte and end-of-text transfers over %0d texts, %0d tokens compared.",
             items_sent, n_texts, tokens_checked);
    $display("Both channels idled at random; output held off once for %0d cycles.",
             LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("json_token_lexer_unit test passed");
    end else begin
      $display("json_token_lexer_unit test failed");
    end
    $finish;
  end

endmodule
